// File: design/mau_pkg.sv
// Shared types, codes and the modular add step for the modular arithmetic unit.
`timescale 1ns / 1ps
package mau_pkg;

    localparam int WORD_BITS = 64;
    localparam int CNT_BITS  = $clog2(WORD_BITS);
    localparam logic [CNT_BITS-1:0] LAST_BIT = CNT_BITS'(WORD_BITS - 1);

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [2:0] {
        ACT_REDUCE  = 3'd0,
        ACT_ADD     = 3'd1,
        ACT_SUB     = 3'd2,
        ACT_MUL     = 3'd3,
        ACT_POW     = 3'd4,
        ACT_NEGATE  = 3'd5,
        ACT_INVERSE = 3'd6,
        ACT_SWITCH  = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        REG_MODULUS = 2'd0,
        REG_TARGET  = 2'd1
    } reg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED,
        S_MDBL,
        S_MADD,
        S_RET,
        S_DISPATCH,
        S_PCHK,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        RET_A,
        RET_B,
        RET_MUL,
        RET_PR,
        RET_SQ,
        RET_SWN,
        RET_SWP
    } ret_t;

    typedef struct packed {
        action_t action;
        word_t   operand_a;
        word_t   operand_b;
    } cmd_t;

    // (x + y + cin) mod m, with x, y < m; carry into bit WORD_BITS is kept
    function automatic word_t mod_add(word_t x, word_t y, logic cin, word_t m);
        logic [WORD_BITS:0] s;
        s = {1'b0, x} + {1'b0, y} + {{WORD_BITS{1'b0}}, cin};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[WORD_BITS-1:0];
    endfunction

endpackage

// File: design/mau_core.sv
// Bit-serial sequencer: reductions, add, subtract, negate, multiplies, square-and-multiply power and inverse, switch.
`timescale 1ns / 1ps
module mau_core
    import mau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  word_t modulus,
    input  word_t target_modulus,
    input  logic  cmd_valid,
    output logic  cmd_ready,
    input  cmd_t  cmd,
    input  logic  res_ready,
    output logic  res_done,
    output word_t res_data
);

    state_t            state_reg, state_next;
    ret_t              ret_reg, ret_next;
    action_t           act_reg, act_next;
    word_t             b_reg, b_next;
    word_t             ar_reg, ar_next;
    word_t             br_reg, br_next;
    word_t             acc_reg, acc_next;
    word_t             sh_reg, sh_next;
    word_t             x_reg, x_next;
    word_t             base_reg, base_next;
    word_t             pw_reg, pw_next;
    word_t             exp_reg, exp_next;
    word_t             res_reg, res_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic              msel_reg, msel_next;

    word_t add_x, add_y, add_m, add_sum;
    logic  add_c;

    assign add_m   = msel_reg ? target_modulus : modulus;
    assign add_sum = mod_add(add_x, add_y, add_c, add_m);

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= RET_A;
            msel_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            msel_reg  <= msel_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        b_reg    <= b_next;
        ar_reg   <= ar_next;
        br_reg   <= br_next;
        acc_reg  <= acc_next;
        sh_reg   <= sh_next;
        x_reg    <= x_next;
        base_reg <= base_next;
        pw_reg   <= pw_next;
        exp_reg  <= exp_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        act_next   = act_reg;
        b_next     = b_reg;
        ar_next    = ar_reg;
        br_next    = br_reg;
        acc_next   = acc_reg;
        sh_next    = sh_reg;
        x_next     = x_reg;
        base_next  = base_reg;
        pw_next    = pw_reg;
        exp_next   = exp_reg;
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        msel_next  = msel_reg;
        add_x      = acc_reg;
        add_y      = acc_reg;
        add_c      = 1'b0;
        res_done   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    act_next  = cmd.action;
                    b_next    = cmd.operand_b;
                    msel_next = 1'b0;
                    if ((modulus < word_t'(2)) ||
                        ((cmd.action == ACT_SWITCH) && (target_modulus < word_t'(2))))
                    begin
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        sh_next    = cmd.operand_a;
                        acc_next   = '0;
                        cnt_next   = LAST_BIT;
                        ret_next   = RET_A;
                        state_next = S_RED;
                    end
                end
            end

            // remainder step: acc = 2*acc + next bit, mod m
            S_RED:
            begin
                add_c    = sh_reg[WORD_BITS-1];
                acc_next = add_sum;
                sh_next  = sh_reg << 1;
                if (cnt_reg == '0)
                begin
                    state_next = S_RET;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            S_MDBL:
            begin
                acc_next = add_sum;
                if (sh_reg[WORD_BITS-1])
                begin
                    state_next = S_MADD;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = S_RET;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                    sh_next  = sh_reg << 1;
                end
            end

            S_MADD:
            begin
                add_y    = x_reg;
                acc_next = add_sum;
                if (cnt_reg == '0)
                begin
                    state_next = S_RET;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    sh_next    = sh_reg << 1;
                    state_next = S_MDBL;
                end
            end

            S_RET:
            begin
                case (ret_reg)
                    RET_A:
                    begin
                        ar_next    = acc_reg;
                        sh_next    = b_reg;
                        acc_next   = '0;
                        cnt_next   = LAST_BIT;
                        ret_next   = RET_B;
                        state_next = S_RED;
                    end
                    RET_B:
                    begin
                        br_next    = acc_reg;
                        state_next = S_DISPATCH;
                    end
                    RET_PR:
                    begin
                        pw_next    = acc_reg;
                        x_next     = base_reg;
                        sh_next    = base_reg;
                        acc_next   = '0;
                        cnt_next   = LAST_BIT;
                        ret_next   = RET_SQ;
                        state_next = S_MDBL;
                    end
                    RET_SQ:
                    begin
                        base_next  = acc_reg;
                        exp_next   = exp_reg >> 1;
                        state_next = S_PCHK;
                    end
                    RET_SWN:
                    begin
                        res_next   = (acc_reg == '0) ? '0 : target_modulus - acc_reg;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        // plain multiply and positive switch both take acc as is
                        res_next   = acc_reg;
                        state_next = S_DONE;
                    end
                endcase
            end

            S_DISPATCH:
            begin
                state_next = S_DONE;
                case (act_reg)
                    ACT_REDUCE:
                    begin
                        res_next = ar_reg;
                    end
                    ACT_ADD:
                    begin
                        add_x    = ar_reg;
                        add_y    = br_reg;
                        res_next = add_sum;
                    end
                    ACT_SUB:
                    begin
                        res_next = (ar_reg >= br_reg) ? ar_reg - br_reg
                                                      : ar_reg - br_reg + modulus;
                    end
                    ACT_MUL:
                    begin
                        x_next     = ar_reg;
                        sh_next    = br_reg;
                        acc_next   = '0;
                        cnt_next   = LAST_BIT;
                        ret_next   = RET_MUL;
                        state_next = S_MDBL;
                    end
                    ACT_POW:
                    begin
                        pw_next    = word_t'(1);
                        base_next  = ar_reg;
                        exp_next   = b_reg;
                        state_next = S_PCHK;
                    end
                    ACT_NEGATE:
                    begin
                        res_next = (ar_reg == '0) ? '0 : modulus - ar_reg;
                    end
                    ACT_INVERSE:
                    begin
                        pw_next    = word_t'(1);
                        base_next  = ar_reg;
                        exp_next   = modulus - word_t'(2);
                        state_next = S_PCHK;
                    end
                    default:
                    begin
                        // centered switch: values above half map as negatives
                        msel_next = 1'b1;
                        acc_next  = '0;
                        cnt_next  = LAST_BIT;
                        if (ar_reg > (modulus >> 1))
                        begin
                            sh_next  = modulus - ar_reg;
                            ret_next = RET_SWN;
                        end
                        else
                        begin
                            sh_next  = ar_reg;
                            ret_next = RET_SWP;
                        end
                        state_next = S_RED;
                    end
                endcase
            end

            S_PCHK:
            begin
                acc_next = '0;
                cnt_next = LAST_BIT;
                if (exp_reg == '0)
                begin
                    res_next   = pw_reg;
                    state_next = S_DONE;
                end
                else if (exp_reg[0])
                begin
                    x_next     = pw_reg;
                    sh_next    = base_reg;
                    ret_next   = RET_PR;
                    state_next = S_MDBL;
                end
                else
                begin
                    x_next     = base_reg;
                    sh_next    = base_reg;
                    ret_next   = RET_SQ;
                    state_next = S_MDBL;
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    res_done   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/modular_arithmetic_unit.sv
// Top level of the modular arithmetic unit: stream ports, config registers, output stage.
`timescale 1ns / 1ps
// Usage:
//  - s_axis carries one operation per beat: action in tuser, operands in tdata.
//  - m_axis returns one 64-bit result per input beat, in order.
//  - cfg writes modulus (index 0) or target_modulus (index 1); other indexes
//    are ignored. cfg_ready is always high; write only while the unit is idle.
//  - Reduce/add/sub/negate run two bit-serial reductions plus control
//    steps. Multiply adds one shift-and-add pass. Power and inverse run
//    one or two such passes per exponent bit. Switch adds a third
//    bit-serial reduction.
//  - One item is in work at a time: s_axis_tready is high only while the
//    sequencer is idle. The single shared 65-bit modular adder sets the pace.
//  - A finished result sits in the output register; the next item is taken
//    while it waits. If the receiver stalls, the sequencer holds its next
//    result until the output register frees up.
//  - Reset sets both moduli to 2 and empties the output stage.
//  - A modulus below 2 (or target below 2 for switch) yields 0.
module modular_arithmetic_unit
    import mau_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // operand_a [63:0], operand_b [127:64]
    input  logic [7:0]   s_axis_tuser,   // action [2:0], zero pad above
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // result [63:0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    word_t modulus_reg, modulus_next;
    word_t target_reg, target_next;
    logic  out_valid_reg, out_valid_next;
    word_t out_data_reg, out_data_next;

    cmd_t  cmd;
    logic  res_ready;
    logic  res_done;
    word_t res_data;

    assign cfg_ready = 1'b1;

    assign cmd.action    = action_t'(s_axis_tuser[2:0]);
    assign cmd.operand_a = s_axis_tdata[63:0];
    assign cmd.operand_b = s_axis_tdata[127:64];

    // result may move into the output register when it is empty or draining
    assign res_ready = !out_valid_reg || m_axis_tready;

    mau_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .modulus        (modulus_reg),
        .target_modulus (target_reg),
        .cmd_valid      (s_axis_tvalid),
        .cmd_ready      (s_axis_tready),
        .cmd            (cmd),
        .res_ready      (res_ready),
        .res_done       (res_done),
        .res_data       (res_data)
    );

    always_comb
    begin
        modulus_next   = modulus_reg;
        target_next    = target_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MODULUS: modulus_next = cfg_data;
                REG_TARGET:  target_next  = cfg_data;
                default:     ;
            endcase
        end
        if (res_done)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_data;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= word_t'(2);
            target_reg    <= word_t'(2);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            modulus_reg   <= modulus_next;
            target_reg    <= target_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// File: design/mau_checker.sv
// Port-level assertions for the modular arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
module mau_checker
    import mau_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata,
    input logic         cfg_ready
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

    // one item at a time: input closes right after a beat is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while item in work");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port stalled");

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_ready     (cfg_ready)
);
